@@ design/trbf_pkg.sv @@
// Shared types and codes for the two-reader broadcast FIFO.
package trbf_pkg;

    // Default number of entries in the ring
    localparam int DEPTH_DEFAULT = 16;

    // Field widths
    localparam int ID_W     = 16;
    localparam int SAMPLE_W = 64;
    localparam int STAMP_W  = 64;
    localparam int STATUS_W = 2;

    // Command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    // Reader select codes
    localparam logic READER_A = 1'b0;
    localparam logic READER_B = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_SUCCESS = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_DATA = 2'd1;
    localparam logic [STATUS_W-1:0] ST_END     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    // One stored entry
    typedef struct packed {
        logic                marker;
        logic [ID_W-1:0]     sensor_id;
        logic [SAMPLE_W-1:0] sample_bits;
        logic [STAMP_W-1:0]  time_stamp;
    } t_record;

    // Control states
    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

endpackage

@@ design/trbf_store.sv @@
// Record memory: one write port, one registered read port.
module trbf_store #(
    parameter int DEPTH = trbf_pkg::DEPTH_DEFAULT,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  trbf_pkg::t_record i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output trbf_pkg::t_record o_rd_data
);

    trbf_pkg::t_record r_mem [DEPTH];
    trbf_pkg::t_record r_rd_data;

    // Write one entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read one entry, hold the data until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/two_reader_broadcast_fifo.sv @@
// Top level of the two-reader broadcast FIFO.
//
// Input channel (i_in_valid / o_in_stall) carries commands: insert a record
// or end-of-stream marker, or read for reader A or B. Each command yields
// exactly one result on the output channel (o_out_valid / i_out_stall):
// a status plus, for a successful read, the record's fields.
// Records sit in a ring of DEPTH entries held in one synchronous memory;
// each reader has its own pointer, and an entry is freed once both have
// passed it. Inserts into a full ring return the full status.
// An insert, or a read with nothing new, shows its result in the cycle after
// the transfer; a hitting read goes through the memory's registered read port
// and the S_READ state to the result register, and no new command is taken
// meanwhile. One insert per cycle while the receiver does not stall.
// Reset (synchronous, active low) empties the ring and drops any pending
// result; memory contents are not cleared. While the receiver stalls, the
// result register holds and new commands stall once it is occupied.
module two_reader_broadcast_fifo #(
    parameter int DEPTH = trbf_pkg::DEPTH_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_command,
    input  logic                             i_end_marker,
    input  logic                             i_reader,
    input  logic [trbf_pkg::ID_W-1:0]        i_sensor_id,
    input  logic [trbf_pkg::SAMPLE_W-1:0]    i_sample_bits,
    input  logic [trbf_pkg::STAMP_W-1:0]     i_time_stamp,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [trbf_pkg::STATUS_W-1:0]    o_status,
    output logic [trbf_pkg::ID_W-1:0]        o_out_sensor_id,
    output logic [trbf_pkg::SAMPLE_W-1:0]    o_out_sample_bits,
    output logic [trbf_pkg::STAMP_W-1:0]     o_out_time_stamp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PW = $clog2(2 * DEPTH);
    localparam logic [PW:0]   TWO_D   = (PW + 1)'(2 * DEPTH);
    localparam logic [PW-1:0] PTR_MAX = PW'(2 * DEPTH - 1);
    localparam logic [PW-1:0] D_PTR   = PW'(DEPTH);

    // Forward distance from p to q, modulo twice the depth
    function automatic logic [PW-1:0] f_span(input logic [PW-1:0] p,
                                             input logic [PW-1:0] q);
        logic [PW:0] t;
        if (q >= p) begin
            t = {1'b0, q} - {1'b0, p};
        end else begin
            t = {1'b0, q} + TWO_D - {1'b0, p};
        end
        return t[PW-1:0];
    endfunction

    // Advance a pointer with wrap
    function automatic logic [PW-1:0] f_next(input logic [PW-1:0] p);
        return (p == PTR_MAX) ? '0 : p + 1'b1;
    endfunction

    // Entry slot of a pointer
    function automatic logic [AW-1:0] f_slot(input logic [PW-1:0] p);
        logic [PW-1:0] s;
        s = (p >= D_PTR) ? p - D_PTR : p;
        return s[AW-1:0];
    endfunction

    trbf_pkg::t_state r_state, n_state;
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_ptr_a, n_ptr_a;
    logic [PW-1:0] r_ptr_b, n_ptr_b;
    logic [PW-1:0] r_oldest, n_oldest;
    logic          r_out_valid, n_out_valid;
    logic [trbf_pkg::STATUS_W-1:0] r_status, n_status;
    logic [trbf_pkg::ID_W-1:0]     r_id, n_id;
    logic [trbf_pkg::SAMPLE_W-1:0] r_sample, n_sample;
    logic [trbf_pkg::STAMP_W-1:0]  r_stamp, n_stamp;

    logic              out_free;
    logic              in_accept;
    logic              full;
    logic              rd_empty;
    logic [PW-1:0]     rd_ptr;
    logic              mem_wr_en;
    logic              mem_rd_en;
    logic [AW-1:0]     mem_wr_addr;
    logic [AW-1:0]     mem_rd_addr;
    trbf_pkg::t_record mem_wr_data;
    trbf_pkg::t_record mem_rd_data;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == trbf_pkg::S_IDLE) && out_free);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign full       = f_span(r_oldest, r_wp) >= D_PTR;
    assign rd_ptr     = (i_reader == trbf_pkg::READER_B) ? r_ptr_b : r_ptr_a;
    assign rd_empty   = (rd_ptr == r_wp);

    // Memory write and read requests
    assign mem_wr_en   = in_accept && (i_command == trbf_pkg::CMD_INSERT) && !full;
    assign mem_wr_addr = f_slot(r_wp);
    assign mem_wr_data = '{marker:      i_end_marker,
                           sensor_id:   i_sensor_id,
                           sample_bits: i_sample_bits,
                           time_stamp:  i_time_stamp};
    assign mem_rd_en   = in_accept && (i_command == trbf_pkg::CMD_READ) && !rd_empty;
    assign mem_rd_addr = f_slot(rd_ptr);

    trbf_store #(
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (mem_wr_en),
        .i_wr_addr(mem_wr_addr),
        .i_wr_data(mem_wr_data),
        .i_rd_en  (mem_rd_en),
        .i_rd_addr(mem_rd_addr),
        .o_rd_data(mem_rd_data)
    );

    // Next state, pointers and result
    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_ptr_a     = r_ptr_a;
        n_ptr_b     = r_ptr_b;
        n_oldest    = r_oldest;
        n_out_valid = r_out_valid && i_out_stall;
        n_status    = r_status;
        n_id        = r_id;
        n_sample    = r_sample;
        n_stamp     = r_stamp;
        case (r_state)
            trbf_pkg::S_IDLE: begin
                if (in_accept) begin
                    if (i_command == trbf_pkg::CMD_INSERT) begin
                        n_out_valid = 1'b1;
                        n_id        = '0;
                        n_sample    = '0;
                        n_stamp     = '0;
                        if (full) begin
                            n_status = trbf_pkg::ST_FULL;
                        end else begin
                            n_status = trbf_pkg::ST_SUCCESS;
                            n_wp     = f_next(r_wp);
                        end
                    end else if (rd_empty) begin
                        n_out_valid = 1'b1;
                        n_status    = trbf_pkg::ST_NO_DATA;
                        n_id        = '0;
                        n_sample    = '0;
                        n_stamp     = '0;
                    end else begin
                        // advance the reader and recompute the slower one
                        if (i_reader == trbf_pkg::READER_B) begin
                            n_ptr_b = f_next(r_ptr_b);
                        end else begin
                            n_ptr_a = f_next(r_ptr_a);
                        end
                        if (f_span(r_oldest, n_ptr_a) < f_span(r_oldest, n_ptr_b)) begin
                            n_oldest = n_ptr_a;
                        end else begin
                            n_oldest = n_ptr_b;
                        end
                        n_state = trbf_pkg::S_READ;
                    end
                end
            end
            trbf_pkg::S_READ: begin
                // memory data is ready; hand it on once the result register frees
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = trbf_pkg::S_IDLE;
                    if (mem_rd_data.marker) begin
                        n_status = trbf_pkg::ST_END;
                        n_id     = '0;
                        n_sample = '0;
                        n_stamp  = '0;
                    end else begin
                        n_status = trbf_pkg::ST_SUCCESS;
                        n_id     = mem_rd_data.sensor_id;
                        n_sample = mem_rd_data.sample_bits;
                        n_stamp  = mem_rd_data.time_stamp;
                    end
                end
            end
            default: begin
                n_state = trbf_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= trbf_pkg::S_IDLE;
            r_wp        <= '0;
            r_ptr_a     <= '0;
            r_ptr_b     <= '0;
            r_oldest    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_ptr_a     <= n_ptr_a;
            r_ptr_b     <= n_ptr_b;
            r_oldest    <= n_oldest;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_id     <= n_id;
        r_sample <= n_sample;
        r_stamp  <= n_stamp;
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_status;
    assign o_out_sensor_id   = r_id;
    assign o_out_sample_bits = r_sample;
    assign o_out_time_stamp  = r_stamp;

`ifndef SYNTH
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_span(r_oldest, r_wp) <= D_PTR)
        else $error("ring holds more than DEPTH entries");

    a_readers_behind_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (f_span(r_oldest, r_ptr_a) <= f_span(r_oldest, r_wp)) &&
        (f_span(r_oldest, r_ptr_b) <= f_span(r_oldest, r_wp)))
        else $error("a reader pointer passed the write pointer");

    a_full_holds_wp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && (i_command == trbf_pkg::CMD_INSERT) && full |=> $stable(r_wp))
        else $error("write pointer moved on a refused insert");

    a_hit_goes_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_rd_en |=> (r_state == trbf_pkg::S_READ) && o_in_stall)
        else $error("memory read not followed by read state");
`endif

endmodule
